[rtl/tqsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tqsa_pkg
// Shared types and codes for the two-queue shared-array block.
// ----------------------------------------------------------------------------
package tqsa_pkg;

    localparam int DEPTH_DEF = 8;

    // request codes
    typedef enum logic [1:0] {
        FUNC_PUSH_L = 2'd0,
        FUNC_PUSH_R = 2'd1,
        FUNC_POP_L  = 2'd2,
        FUNC_POP_R  = 2'd3
    } t_func;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // controller -> datapath commands
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // run the captured request against pointers and store
    } t_cmd;

endpackage
`default_nettype wire

[rtl/tqsa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tqsa_ctrl
// Sequencer: accept, execute, present result strobe.
// ----------------------------------------------------------------------------
module tqsa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output tqsa_pkg::t_cmd     o_cmd,
    output logic               o_busy,
    output logic               o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;
    logic   w_accept;

    assign w_accept   = i_start && !r_busy;
    assign o_cmd.load = w_accept;
    assign o_cmd.exec = (r_state == S_EXEC);
    assign o_busy     = r_busy;
    assign o_valid    = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE, S_RESP: begin
                    r_valid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/tqsa_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tqsa_dp
// Pointers, shared store and result registers.
// ----------------------------------------------------------------------------
module tqsa_dp #(
    parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tqsa_pkg::t_cmd       i_cmd,
    input  wire logic [1:0]           i_func,
    input  wire logic signed [31:0]   i_value,
    output logic signed [31:0]        o_data,
    output logic [1:0]                o_status
);

    localparam int PW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam logic [PW-1:0] PDEPTH = PW'(DEPTH);

    logic [31:0]        r_mem [DEPTH];

    tqsa_pkg::t_func    r_func;
    logic [31:0]        r_value;

    // right front kept as index plus one, so it never goes negative
    logic [PW-1:0]      r_lfront, r_lfill, r_rfront1, r_rfill;
    logic [PW-1:0]      n_lfront, n_lfill, n_rfront1, n_rfill;

    logic [31:0]        r_data;
    logic [1:0]         r_status;
    logic [1:0]         w_status;
    logic               w_wr, w_rd;
    logic [PW-1:0]      w_ptr;
    logic [AW-1:0]      w_addr;

    always_comb begin
        n_lfront  = r_lfront;
        n_lfill   = r_lfill;
        n_rfront1 = r_rfront1;
        n_rfill   = r_rfill;
        w_status  = tqsa_pkg::ST_DONE;
        w_wr      = 1'b0;
        w_rd      = 1'b0;
        w_ptr     = r_lfill;
        case (r_func)
            tqsa_pkg::FUNC_PUSH_L: begin
                w_ptr = r_lfill;
                if (r_lfill >= r_rfill) begin
                    w_status = tqsa_pkg::ST_FULL;
                end else begin
                    w_wr    = 1'b1;
                    n_lfill = r_lfill + 1'b1;
                end
            end
            tqsa_pkg::FUNC_PUSH_R: begin
                w_ptr = r_rfill - 1'b1;
                if (r_lfill >= r_rfill) begin
                    w_status = tqsa_pkg::ST_FULL;
                end else begin
                    w_wr    = 1'b1;
                    n_rfill = r_rfill - 1'b1;
                end
            end
            tqsa_pkg::FUNC_POP_L: begin
                w_ptr = r_lfront;
                if (r_lfront >= r_lfill) begin
                    w_status = tqsa_pkg::ST_EMPTY;
                end else begin
                    w_rd     = 1'b1;
                    n_lfront = r_lfront + 1'b1;
                end
            end
            tqsa_pkg::FUNC_POP_R: begin
                w_ptr = r_rfront1 - 1'b1;
                if (r_rfront1 <= r_rfill || r_rfront1 == '0) begin
                    w_status = tqsa_pkg::ST_EMPTY;
                end else begin
                    w_rd      = 1'b1;
                    n_rfront1 = r_rfront1 - 1'b1;
                end
            end
            default: w_status = tqsa_pkg::ST_DONE;
        endcase
    end

    assign w_addr = w_ptr[AW-1:0];

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= tqsa_pkg::t_func'(i_func);
            r_value <= i_value;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfront  <= '0;
            r_lfill   <= '0;
            r_rfront1 <= PDEPTH;
            r_rfill   <= PDEPTH;
        end else if (i_cmd.exec) begin
            r_lfront  <= n_lfront;
            r_lfill   <= n_lfill;
            r_rfront1 <= n_rfront1;
            r_rfill   <= n_rfill;
        end
    end

    // store: at most one write or one registered read per request
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_wr) begin
                r_mem[w_addr] <= r_value;
            end
            r_data   <= w_rd ? r_mem[w_addr] : 32'd0;
            r_status <= w_status;
        end
    end

    assign o_data   = r_data;
    assign o_status = r_status;

endmodule
`default_nettype wire

[rtl/two_queues_shared_array.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_queues_shared_array
// Two linear FIFOs in one store: left grows up from 0, right grows down from
// the top. One result per request: popped data and a status code.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------
//  request   | start / busy       | i_func[1:0], i_value[31:0]
//  result    | o_valid (1 cycle)  | o_data[31:0], o_status[1:0]
//
//  A request is taken on a clock edge with start high and busy low.
//  busy is high for the one execute cycle; the result strobe follows in the
//  next cycle, together with the registered store read.
//  A new request may be issued in the same cycle the result is shown.
//  The result receiver cannot stall: o_valid lasts exactly one cycle.
//  Synchronous active-low reset clears the pointers; store contents are
//  left as they are and popped slots are only recovered by reset.
// ----------------------------------------------------------------------------
module two_queues_shared_array #(
    parameter int DEPTH = tqsa_pkg::DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_func,
    input  wire logic signed [31:0]  i_value,
    output logic                     o_valid,
    output logic signed [31:0]       o_data,
    output logic [1:0]               o_status
);

    tqsa_pkg::t_cmd w_cmd;

    // sequencer: accept -> execute -> strobe
    tqsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // pointers, full/empty checks and the shared store
    tqsa_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_func   (i_func),
        .i_value  (i_value),
        .o_data   (o_data),
        .o_status (o_status)
    );

endmodule
`default_nettype wire

[rtl/tqsa_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tqsa_chk
// Port-level checks for two_queues_shared_array.
// ----------------------------------------------------------------------------
module tqsa_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         start,
    input wire logic         busy,
    input wire logic         o_valid,
    input wire logic [31:0]  o_data,
    input wire logic [1:0]   o_status
);

    // each accepted request yields a strobe after its execute state
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("missing result strobe");

    // a strobe never shows up without a request in flight (busy) before it
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without request");

    // refused requests carry zero data
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != tqsa_pkg::ST_DONE) |-> (o_data == 32'd0))
        else $error("nonzero data on refused request");

    // status code on a strobe stays legal: done, full or empty
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == tqsa_pkg::ST_DONE || o_status == tqsa_pkg::ST_FULL
                     || o_status == tqsa_pkg::ST_EMPTY))
        else $error("bad status code");

endmodule

bind two_queues_shared_array tqsa_chk u_tqsa_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_data   (o_data),
    .o_status (o_status)
);
`default_nettype wire
